FILE: rtl/dsh_pkg.sv
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared constants, types and helpers of the diamond-square heightmap core.
// ----------------------------------------------------------------------------
package dsh_pkg;

	localparam int MAX_LOG2_SIZE = 6;
	localparam int CW            = MAX_LOG2_SIZE;          // coordinate width
	localparam int AW            = 2 * MAX_LOG2_SIZE;      // height store address
	localparam int LW            = $clog2(MAX_LOG2_SIZE + 1);
	localparam int HW            = 24;

	localparam logic [1:0] CFG_INITIAL_RANGE = 2'd0;
	localparam logic [1:0] CFG_RANGE_DECAY   = 2'd1;
	localparam logic [1:0] CFG_GRID_LOG2     = 2'd2;

	localparam logic [1:0] PH_DIAMOND = 2'd0;
	localparam logic [1:0] PH_RIGHT   = 2'd1;
	localparam logic [1:0] PH_LOWER   = 2'd2;

	typedef struct packed {
		logic [CW-1:0]        x_coord;
		logic [CW-1:0]        z_coord;
		logic signed [HW-1:0] height;
		logic                 last_point;
	} dsh_res_t;

	// wrapped (x, z) to store address for a grid of side 2^lg
	function automatic logic [AW-1:0] cell_idx(input logic [CW-1:0] x,
		input logic [CW-1:0] z, input logic [LW-1:0] lg);
		logic [CW-1:0] m;
		logic [AW-1:0] ix;
		begin
			m  = CW'((1 << lg) - 1);
			ix = AW'(x & m) | (AW'(z & m) << lg);
			return ix;
		end
	endfunction

endpackage

FILE: rtl/dsh_queue.sv
// ----------------------------------------------------------------------------
// dsh_queue
// Two-word queue between the input port and the height engine.
// ----------------------------------------------------------------------------
module dsh_queue import dsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] in_data,
	output logic        q_valid,
	input  logic        q_pop,
	output logic [15:0] q_data
);

	logic [15:0] slot_q [2];
	logic        rd_q, wr_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = slot_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/dsh_engine.sv
// ----------------------------------------------------------------------------
// dsh_engine
// Walks the diamond-square visit order, reads four neighbours from the
// height store, writes the new height and hands out one result per word.
// ----------------------------------------------------------------------------
module dsh_engine import dsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        q_valid,
	output logic        q_pop,
	input  logic [15:0] q_data,
	output logic        res_valid,
	input  logic        res_ready,
	output dsh_res_t    res
);

	localparam logic [2:0] ST_TAKE = 3'd0;
	localparam logic [2:0] ST_RB   = 3'd1;
	localparam logic [2:0] ST_RC   = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  st_q;
	logic [15:0] init_q, decay_q, rng_q;
	logic [2:0]  grid_q;
	logic [LW-1:0] alog_q, lvl_q;
	logic [1:0]  phase_q;
	logic [CW-1:0] cx_q, cz_q, px_q, pz_q;
	logic [AW-1:0] adb_q, adc_q, add_q;
	logic signed [34:0] prod_q;
	logic signed [25:0] sum_q;
	dsh_res_t    res_q;

	logic [HW-1:0] mem [1 << AW];
	logic [AW-1:0] maddr;
	logic          mwe;
	logic [HW-1:0] rd_q;
	logic          rzero_q;
	logic signed [HW-1:0] rdv;

	// effective state, with a generation start folded in
	logic          take, start;
	logic [LW-1:0] clampg, e_log2, e_lvl;
	logic [15:0]   e_rng;
	logic [CW-1:0] h0, e_cx, e_cz, px, pz;
	logic [CW-1:0] ax, bx, az, bz;
	logic [AW-1:0] ada, adb, adc, add;
	logic signed [17:0] twou;

	// write-stage values
	logic [CW-1:0] h4;
	logic [CW:0]   fs, sz, nx, nz;
	logic signed [25:0] tot, val;
	logic signed [22:0] disp;
	logic [31:0]   rprod;
	logic [19:0]   rnext;
	logic signed [HW-1:0] hsat;

	assign take = (st_q == ST_TAKE) || (st_q == ST_OUT && res_ready);
	assign q_pop = take;
	assign res_valid = (st_q == ST_OUT);
	assign res = res_q;

	always_comb begin
		if (grid_q == 3'd0) clampg = LW'(1);
		else if (32'(grid_q) > MAX_LOG2_SIZE) clampg = LW'(MAX_LOG2_SIZE);
		else clampg = LW'(grid_q);
		start  = (phase_q == PH_DIAMOND) && (cx_q == '0) && (cz_q == '0);
		e_log2 = start ? clampg : alog_q;
		e_lvl  = start ? clampg : lvl_q;
		e_rng  = start ? init_q : rng_q;
		h0     = CW'(1 << (e_lvl - LW'(1)));
		e_cx   = start ? h0 : cx_q;
		e_cz   = start ? h0 : cz_q;
		unique case (phase_q)
			PH_RIGHT: begin
				px = e_cx + h0;
				pz = e_cz;
			end
			PH_LOWER: begin
				px = e_cx;
				pz = e_cz + h0;
			end
			default: begin
				px = e_cx;
				pz = e_cz;
			end
		endcase
		ax = px - h0;
		bx = px + h0;
		az = pz - h0;
		bz = pz + h0;
		if (phase_q == PH_DIAMOND) begin
			ada = cell_idx(ax, az, e_log2);
			adb = cell_idx(bx, az, e_log2);
			adc = cell_idx(ax, bz, e_log2);
			add = cell_idx(bx, bz, e_log2);
		end else begin
			ada = cell_idx(ax, pz, e_log2);
			adb = cell_idx(bx, pz, e_log2);
			adc = cell_idx(px, az, e_log2);
			add = cell_idx(px, bz, e_log2);
		end
		twou = $signed({1'b0, q_data, 1'b0}) - 18'sd65536;
	end

	// single-port store; cell (0,0) is never written, so it reads as zero
	always_comb begin
		mwe = (st_q == ST_WR);
		unique case (st_q)
			ST_RB:   maddr = adb_q;
			ST_RC:   maddr = adc_q;
			ST_RD:   maddr = add_q;
			ST_WR:   maddr = cell_idx(px_q, pz_q, alog_q);
			default: maddr = ada;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mwe) mem[maddr] <= hsat;
		rd_q    <= mem[maddr];
		rzero_q <= (maddr == '0);
	end

	assign rdv = rzero_q ? '0 : $signed(rd_q);

	always_comb begin
		h4    = CW'(1 << (lvl_q - LW'(1)));
		fs    = (CW+1)'(1 << lvl_q);
		sz    = (CW+1)'(1 << alog_q);
		nx    = {1'b0, cx_q} + fs;
		nz    = {1'b0, cz_q} + fs;
		tot   = sum_q + 26'(rdv);
		disp  = 23'(prod_q >>> 12);
		val   = (tot >>> 2) + 26'(disp);
		if (val > 26'sd8388607) hsat = 24'sh7fffff;
		else if (val < -26'sd8388608) hsat = 24'sh800000;
		else hsat = val[HW-1:0];
		rprod = rng_q * decay_q;
		rnext = rprod[31:12];
	end

	always_ff @(posedge clk) begin
		if (take && q_valid) begin
			px_q   <= px;
			pz_q   <= pz;
			adb_q  <= adb;
			adc_q  <= adc;
			add_q  <= add;
			prod_q <= $signed({1'b0, e_rng}) * twou;
		end
		unique case (st_q)
			ST_RB:   sum_q <= 26'(rdv);
			ST_RC,
			ST_RD:   sum_q <= sum_q + 26'(rdv);
			default: sum_q <= sum_q;
		endcase
		if (st_q == ST_WR) begin
			res_q.x_coord <= px_q;
			res_q.z_coord <= pz_q;
			res_q.height  <= hsat;
			res_q.last_point <= (phase_q == PH_LOWER) && (nx >= sz) && (nz >= sz)
				&& (lvl_q == LW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_TAKE;
			init_q  <= 16'd819;
			decay_q <= 16'd2048;
			grid_q  <= 3'd6;
			alog_q  <= LW'(MAX_LOG2_SIZE);
			lvl_q   <= LW'(MAX_LOG2_SIZE);
			rng_q   <= 16'd819;
			phase_q <= PH_DIAMOND;
			cx_q    <= '0;
			cz_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INITIAL_RANGE: init_q  <= cfg_data;
					CFG_RANGE_DECAY:   decay_q <= cfg_data;
					CFG_GRID_LOG2:     grid_q  <= cfg_data[2:0];
					default: ;
				endcase
			end
			unique case (st_q)
				ST_TAKE, ST_OUT: begin
					if (take && q_valid) begin
						alog_q <= e_log2;
						lvl_q  <= e_lvl;
						rng_q  <= e_rng;
						cx_q   <= e_cx;
						cz_q   <= e_cz;
						st_q   <= ST_RB;
					end else if (take) begin
						st_q <= ST_TAKE;
					end
				end
				ST_RB: st_q <= ST_RC;
				ST_RC: st_q <= ST_RD;
				ST_RD: st_q <= ST_WR;
				ST_WR: begin
					st_q <= ST_OUT;
					// advance the visit cursor
					if (phase_q == PH_DIAMOND) begin
						if (nx >= sz) begin
							cx_q <= h4;
							if (nz >= sz) begin
								phase_q <= PH_RIGHT;
								cx_q    <= '0;
								cz_q    <= '0;
							end else begin
								cz_q <= nz[CW-1:0];
							end
						end else begin
							cx_q <= nx[CW-1:0];
						end
					end else if (phase_q == PH_RIGHT) begin
						phase_q <= PH_LOWER;
					end else begin
						phase_q <= PH_RIGHT;
						if (nx >= sz) begin
							cx_q <= '0;
							if (nz >= sz) begin
								rng_q   <= (rnext > 20'd65535) ? 16'hffff : rnext[15:0];
								lvl_q   <= lvl_q - LW'(1);
								phase_q <= PH_DIAMOND;
								if (lvl_q == LW'(1)) begin
									cz_q <= '0;
								end else begin
									cx_q <= CW'(1 << (lvl_q - LW'(2)));
									cz_q <= CW'(1 << (lvl_q - LW'(2)));
								end
							end else begin
								cz_q <= nz[CW-1:0];
							end
						end else begin
							cx_q <= nx[CW-1:0];
						end
					end
				end
				default: st_q <= ST_TAKE;
			endcase
		end
	end

endmodule

FILE: rtl/diamond_square_heightmap_core.sv
// Each word's result is registered in the engine and again in the output register.
// The engine works on one word at a time, as its four neighbour reads and one
// write go through the single port of the height store.
// Reset: arst_n clears control state and restores register defaults; the
// height store needs no clearing pass, its unwritten corner reads as zero.
// ----------------------------------------------------------------------------
// diamond_square_heightmap_core
// Wrapping diamond-square heightmap generator, one grid point per word.
// ----------------------------------------------------------------------------
module diamond_square_heightmap_core import dsh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        random_fraction,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CW-1:0]      x_coord,
	output logic [CW-1:0]      z_coord,
	output logic signed [23:0] height,
	output logic               last_point
);

	logic        q_valid, q_pop;
	logic [15:0] q_data;
	logic        res_valid, res_ready;
	dsh_res_t    res, out_q;
	logic        out_valid_q;

	dsh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (random_fraction),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data)
	);

	dsh_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	assign out_valid  = out_valid_q;
	assign x_coord    = out_q.x_coord;
	assign z_coord    = out_q.z_coord;
	assign height     = out_q.height;
	assign last_point = out_q.last_point;

`ifndef SYNTHESIS
	a_res_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> out_valid)
		else $error("result word lost on way to output register");
	a_res_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("engine result changed while stalled");
	a_empty_room: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> in_ready)
		else $error("empty queue refuses input");
`endif

endmodule

FILE: tb/tb_diamond_square_heightmap_core.sv
// ----------------------------------------------------------------------------
// tb_diamond_square_heightmap_core
// Drives random fractions into the heightmap core and checks every emitted
// grid point against a cycle-free model of the diamond-square sweep.
// ----------------------------------------------------------------------------
module tb_diamond_square_heightmap_core;
	import dsh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        random_fraction = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CW-1:0]      x_coord;
	logic [CW-1:0]      z_coord;
	logic signed [23:0] height;
	logic               last_point;

	diamond_square_heightmap_core DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state
	int             hmap [0:4095];
	int unsigned    m_lvl, m_ph, m_cx, m_cz, m_rng, m_act;
	int unsigned    r_init = 819, r_decay = 2048, r_grid = 6;
	dsh_res_t       pending_points [$];
	int             errors = 0;
	int             send_idle = 0, recv_stall = 0;
	int             hold_off = 0;

	function automatic int unsigned clamp_grid(int unsigned g);
		if (g < 1) return 1;
		if (g > MAX_LOG2_SIZE) return MAX_LOG2_SIZE;
		return g;
	endfunction

	function automatic int unsigned addr_of(int unsigned x, int unsigned z);
		int unsigned m;
		m = (1 << m_act) - 1;
		return ((x & m) | ((z & m) << m_act)) & 12'hFFF;
	endfunction

	task automatic predict_point(input logic [15:0] u);
		int unsigned fs, h, s, px, pz;
		longint sum, avg, prod, disp, val, r;
		dsh_res_t p;
		bit last;
		last = 0;
		if (m_ph == PH_DIAMOND && m_cx == 0 && m_cz == 0) begin
			for (int i = 0; i < 4096; i++) hmap[i] = 0;
			m_act = clamp_grid(r_grid);
			m_lvl = m_act;
			m_rng = r_init;
			m_cx = 1 << (m_lvl - 1);
			m_cz = m_cx;
		end
		fs = 1 << m_lvl;
		h = fs >> 1;
		s = 1 << m_act;
		if (m_ph == PH_DIAMOND) begin
			px = m_cx; pz = m_cz;
			sum = longint'(hmap[addr_of(px+s-h, pz+s-h)]) + hmap[addr_of(px+h, pz+s-h)]
				+ hmap[addr_of(px+s-h, pz+h)] + hmap[addr_of(px+h, pz+h)];
		end else begin
			px = (m_ph == PH_RIGHT) ? m_cx + h : m_cx;
			pz = (m_ph == PH_RIGHT) ? m_cz : m_cz + h;
			sum = longint'(hmap[addr_of(px+s-h, pz)]) + hmap[addr_of(px+h, pz)]
				+ hmap[addr_of(px, pz+s-h)] + hmap[addr_of(px, pz+h)];
		end
		avg = sum >>> 2;
		prod = longint'(m_rng) * (2 * longint'(u) - 65536);
		disp = prod >>> 12;
		val = avg + disp;
		if (val > 8388607) val = 8388607;
		if (val < -8388608) val = -8388608;
		hmap[addr_of(px, pz)] = int'(val);
		if (m_ph == PH_DIAMOND) begin
			m_cx += fs;
			if (m_cx >= s) begin
				m_cx = h;
				m_cz += fs;
				if (m_cz >= s) begin
					m_ph = PH_RIGHT; m_cx = 0; m_cz = 0;
				end
			end
		end else if (m_ph == PH_RIGHT) begin
			m_ph = PH_LOWER;
		end else begin
			m_ph = PH_RIGHT;
			m_cx += fs;
			if (m_cx >= s) begin
				m_cx = 0;
				m_cz += fs;
				if (m_cz >= s) begin
					r = (longint'(m_rng) * r_decay) >> 12;
					m_rng = (r > 65535) ? 65535 : int'(r);
					m_lvl--;
					m_ph = PH_DIAMOND;
					if (m_lvl == 0) begin
						last = 1;
						m_cx = 0; m_cz = 0;
						m_act = clamp_grid(r_grid);
						m_lvl = m_act;
						m_rng = r_init;
					end else begin
						m_cx = 1 << (m_lvl - 1);
						m_cz = m_cx;
					end
				end
			end
		end
		p.x_coord = px[CW-1:0];
		p.z_coord = pz[CW-1:0];
		p.height = val[23:0];
		p.last_point = last;
		pending_points.push_back(p);
	endtask

	// valid drops only while idling or draining, so back-to-back words never gap
	task automatic send_word(input logic [15:0] u);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		random_fraction <= u;
		predict_point(u);
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_INITIAL_RANGE: r_init = 32'(v);
			CFG_RANGE_DECAY:   r_decay = 32'(v);
			CFG_GRID_LOG2:     r_grid = 32'(v[2:0]);
			default: ;
		endcase
	endtask

	// words until the current generation ends
	task automatic finish_generation();
		do send_word(16'($urandom)); while (!(m_ph == PH_DIAMOND && m_cx == 0 && m_cz == 0));
	endtask

	task automatic test_directed();
		write_reg(CFG_GRID_LOG2, 16'd1);
		write_reg(CFG_INITIAL_RANGE, 16'hFFFF);
		write_reg(CFG_RANGE_DECAY, 16'hFFFF);
		send_word(16'h0000); send_word(16'hFFFF); send_word(16'h8000);
		drain();
		write_reg(CFG_GRID_LOG2, 16'd0);
		repeat (3) send_word(16'hFFFF);
		// grid and initial-range changes mid-generation wait for the next start; decay does not
		send_word(16'h0000);
		drain();
		write_reg(CFG_GRID_LOG2, 16'd7);
		write_reg(CFG_INITIAL_RANGE, 16'd0);
		write_reg(CFG_RANGE_DECAY, 16'd0);
		write_reg(CFG_GRID_LOG2, 16'd2);
		repeat (15) send_word(16'h5555);
		finish_generation();
		drain();
	endtask

	task automatic test_random(input int unsigned grid, input int n);
		write_reg(CFG_GRID_LOG2, 16'(grid[2:0]));
		write_reg(CFG_INITIAL_RANGE, 16'($urandom));
		write_reg(CFG_RANGE_DECAY,
			$urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8192)));
		repeat (n) send_word(16'($urandom));
		finish_generation();
		drain();
	endtask

	task automatic test_backpressure();
		hold_off = 300;
		write_reg(CFG_GRID_LOG2, 16'd3);
		repeat (40) send_word(16'($urandom));
		finish_generation();
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		dsh_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected word x=%0d z=%0d", x_coord, z_coord);
				errors++;
			end else begin
				e = pending_points.pop_front();
				if (x_coord !== e.x_coord) begin
					$error("x_coord expected %0d got %0d", e.x_coord, x_coord); errors++;
				end
				if (z_coord !== e.z_coord) begin
					$error("z_coord expected %0d got %0d", e.z_coord, z_coord); errors++;
				end
				if (height !== e.height) begin
					$error("height expected %0d got %0d", e.height, height); errors++;
				end
				if (last_point !== e.last_point) begin
					$error("last_point expected %0d got %0d", e.last_point, last_point);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < 4096; i++) hmap[i] = 0;
		m_act = 6; m_lvl = 6; m_ph = PH_DIAMOND; m_cx = 0; m_cz = 0; m_rng = 819;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(5, 300);
		send_idle = 65;
		test_random(4, 200);
		send_idle = 0; recv_stall = 65;
		test_random(3, 200);
		send_idle = 37; recv_stall = 37;
		test_random(4, 200);
		send_idle = 0; recv_stall = 0;
		test_backpressure();
		test_random(2, 100);
		if (errors == 0) $display("diamond_square_heightmap_core: match");
		else $display("diamond_square_heightmap_core: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("diamond_square_heightmap_core: mismatch");
		$finish;
	end
endmodule

FILE: files.f
rtl/dsh_pkg.sv
rtl/dsh_queue.sv
rtl/dsh_engine.sv
rtl/diamond_square_heightmap_core.sv
tb/tb_diamond_square_heightmap_core.sv
